// ===== sv/skvt_pkg.sv =====
// Shared sizes, operation and status codes, and entry types for the sorted key/value table.
package skvt_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

endpackage

// ===== sv/skvt_in_if.sv =====
// Operation channel: valid/ready handshake carrying one table operation.
interface skvt_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [skvt_pkg::KIND_W-1:0]              kind;
  logic signed [skvt_pkg::DATA_W-1:0]       key;
  logic signed [skvt_pkg::DATA_W-1:0]       value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

// ===== sv/skvt_out_if.sv =====
// Result channel: valid/ready handshake carrying one result of a table operation.
interface skvt_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [skvt_pkg::STAT_W-1:0]              status;
  logic signed [skvt_pkg::DATA_W-1:0]       found_key;
  logic signed [skvt_pkg::DATA_W-1:0]       found_value;
  logic                                     last;

  modport source (output valid, output status, output found_key, output found_value,
                  output last, input ready);
  modport sink   (input valid, input status, input found_key, input found_value,
                  input last, output ready);
endinterface

// ===== sv/skvt_ram.sv =====
// Entry store: one write port, one read port, registered read data held when not reading.
module skvt_ram (
  input  logic                clk,
  input  skvt_pkg::ram_wr_t   wr,
  input  skvt_pkg::ram_rd_t   rd,
  output skvt_pkg::entry_t    rdata
);

  skvt_pkg::entry_t mem [skvt_pkg::DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, registered: data valid in the cycle after the request
  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

// ===== sv/sorted_key_value_table_top.sv =====
// Sorted key/value table: sequencer that walks the entry store one read per cycle while
// the result register can take a result; result back-pressure stalls the walk. A new
// operation is taken only in idle, after the result of the last one has been loaded.
// Insert walks down from the top entry, the others walk up; dump gives one result per
// cycle while results are taken.
// Reset clears the entry count and all control state; the entry store is not cleared.
module sorted_key_value_table_top (
  input  logic              clk,
  input  logic              rst,
  skvt_in_if.sink           op,
  skvt_out_if.source        res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                                   state, state_next;
  logic [skvt_pkg::KIND_W-1:0]            kind, kind_next;
  logic signed [skvt_pkg::DATA_W-1:0]     key, key_next;
  logic signed [skvt_pkg::DATA_W-1:0]     value, value_next;
  logic                                   early, early_next;
  logic [skvt_pkg::STAT_W-1:0]            early_st, early_st_next;
  logic                                   found, found_next;
  logic [skvt_pkg::IDX_W-1:0]             issue_idx, issue_idx_next;
  logic [skvt_pkg::CNT_W-1:0]             issue_left, issue_left_next;
  logic [skvt_pkg::IDX_W-1:0]             eval_idx, eval_idx_next;
  logic                                   eval_v, eval_v_next;
  logic [skvt_pkg::CNT_W-1:0]             count, count_next;
  logic                                   out_valid, out_valid_next;
  logic [skvt_pkg::STAT_W-1:0]            out_status, out_status_next;
  logic signed [skvt_pkg::DATA_W-1:0]     out_key, out_key_next;
  logic signed [skvt_pkg::DATA_W-1:0]     out_value, out_value_next;
  logic                                   out_last, out_last_next;

  skvt_pkg::ram_wr_t                      ram_wr;
  skvt_pkg::ram_rd_t                      ram_rd;
  skvt_pkg::entry_t                       rdata;
  logic                                   step;

  skvt_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (rdata)
  );

  assign op.ready        = (state == ST_IDLE);
  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.found_key   = out_key;
  assign res.found_value = out_value;
  assign res.last        = out_last;

  // Advance the walk only when the result register can take a new result
  assign step = !(out_valid && !res.ready);

  // Sequencer: issue one read per step, evaluate the entry read on the step before
  always_comb begin
    state_next      = state;
    kind_next       = kind;
    key_next        = key;
    value_next      = value;
    early_next      = early;
    early_st_next   = early_st;
    found_next      = found;
    issue_idx_next  = issue_idx;
    issue_left_next = issue_left;
    eval_idx_next   = eval_idx;
    eval_v_next     = eval_v;
    count_next      = count;
    out_valid_next  = out_valid && !res.ready;
    out_status_next = out_status;
    out_key_next    = out_key;
    out_value_next  = out_value;
    out_last_next   = out_last;
    ram_wr          = '0;
    ram_rd          = '0;

    case (state)
      ST_IDLE: begin
        if (op.valid) begin
          state_next    = ST_SCAN;
          kind_next     = op.kind;
          key_next      = op.key;
          value_next    = op.value;
          found_next    = 1'b0;
          eval_v_next   = 1'b0;
          early_next    = 1'b0;
          early_st_next = skvt_pkg::STAT_OK;
          if (op.kind == skvt_pkg::KIND_INSERT) begin
            issue_idx_next = skvt_pkg::IDX_W'(count - 1'b1);
            if (count == skvt_pkg::CNT_W'(skvt_pkg::DEPTH)) begin
              early_next    = 1'b1;
              early_st_next = skvt_pkg::STAT_FULL;
            end
          end else begin
            issue_idx_next = '0;
            if (count == '0) begin
              early_next    = 1'b1;
              early_st_next = skvt_pkg::STAT_EMPTY;
            end
          end
          issue_left_next = early_next ? '0 : count;
        end
      end

      ST_SCAN: begin
        if (step) begin
          if (early) begin
            // Table full or empty: one status result, table untouched
            out_valid_next  = 1'b1;
            out_status_next = early_st;
            out_key_next    = '0;
            out_value_next  = '0;
            out_last_next   = 1'b1;
            state_next      = ST_IDLE;
          end else begin
            // Issue the next read of the walk
            if (issue_left != '0) begin
              ram_rd.re       = 1'b1;
              ram_rd.addr     = issue_idx;
              eval_idx_next   = issue_idx;
              eval_v_next     = 1'b1;
              issue_left_next = issue_left - 1'b1;
              if (kind == skvt_pkg::KIND_INSERT) begin
                issue_idx_next = issue_idx - 1'b1;
              end else begin
                issue_idx_next = issue_idx + 1'b1;
              end
            end else begin
              eval_v_next = 1'b0;
            end

            if (eval_v) begin
              // Evaluate the entry returned by the store
              case (kind)
                skvt_pkg::KIND_INSERT: begin
                  ram_wr.we   = 1'b1;
                  ram_wr.addr = skvt_pkg::IDX_W'(eval_idx + 1'b1);
                  if (rdata.key < key) begin
                    ram_wr.data.key   = key;
                    ram_wr.data.value = value;
                    count_next        = count + 1'b1;
                    out_valid_next    = 1'b1;
                    out_status_next   = skvt_pkg::STAT_OK;
                    out_key_next      = '0;
                    out_value_next    = '0;
                    out_last_next     = 1'b1;
                    state_next        = ST_IDLE;
                    eval_v_next       = 1'b0;
                  end else begin
                    ram_wr.data = rdata;
                  end
                end
                skvt_pkg::KIND_DELETE: begin
                  if (found) begin
                    ram_wr.we   = 1'b1;
                    ram_wr.addr = eval_idx - 1'b1;
                    ram_wr.data = rdata;
                  end else if (rdata.key == key) begin
                    found_next = 1'b1;
                  end
                end
                skvt_pkg::KIND_SEARCH: begin
                  if (rdata.value == value) begin
                    out_valid_next  = 1'b1;
                    out_status_next = skvt_pkg::STAT_OK;
                    out_key_next    = rdata.key;
                    out_value_next  = rdata.value;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                    eval_v_next     = 1'b0;
                  end
                end
                default: begin
                  // Dump: one result per entry, last when no read is left
                  out_valid_next  = 1'b1;
                  out_status_next = skvt_pkg::STAT_OK;
                  out_key_next    = rdata.key;
                  out_value_next  = rdata.value;
                  out_last_next   = (issue_left == '0);
                  if (issue_left == '0) begin
                    state_next  = ST_IDLE;
                    eval_v_next = 1'b0;
                  end
                end
              endcase
            end else if (issue_left == '0) begin
              // Walk exhausted
              out_valid_next = 1'b1;
              out_key_next   = '0;
              out_value_next = '0;
              out_last_next  = 1'b1;
              state_next     = ST_IDLE;
              case (kind)
                skvt_pkg::KIND_INSERT: begin
                  ram_wr.we         = 1'b1;
                  ram_wr.addr       = '0;
                  ram_wr.data.key   = key;
                  ram_wr.data.value = value;
                  count_next        = count + 1'b1;
                  out_status_next   = skvt_pkg::STAT_OK;
                end
                skvt_pkg::KIND_DELETE: begin
                  if (found) begin
                    count_next      = count - 1'b1;
                    out_status_next = skvt_pkg::STAT_OK;
                  end else begin
                    out_status_next = skvt_pkg::STAT_NOT_FOUND;
                  end
                end
                default: begin
                  out_status_next = skvt_pkg::STAT_NOT_FOUND;
                end
              endcase
            end
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      eval_v    <= 1'b0;
      early     <= 1'b0;
      found     <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      eval_v    <= eval_v_next;
      early     <= early_next;
      found     <= found_next;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    kind       <= kind_next;
    key        <= key_next;
    value      <= value_next;
    early_st   <= early_st_next;
    issue_idx  <= issue_idx_next;
    issue_left <= issue_left_next;
    eval_idx   <= eval_idx_next;
    out_status <= out_status_next;
    out_key    <= out_key_next;
    out_value  <= out_value_next;
    out_last   <= out_last_next;
  end

  // The table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= skvt_pkg::CNT_W'(skvt_pkg::DEPTH))
    else $error("entry count above depth");

  // The store is written only during a walk
  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ram_wr.we |-> state == ST_SCAN)
    else $error("entry store written outside a walk");

  // The count moves only as a walk completes
  a_count_at_end: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> ($past(state) == ST_SCAN && state == ST_IDLE))
    else $error("entry count changed outside the end of a walk");

  // Pending read data exists only during a walk
  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    eval_v |-> state == ST_SCAN)
    else $error("read data pending outside a walk");

  // A new result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> ($stable(out_key) && $stable(out_status)))
    else $error("waiting result overwritten");

endmodule
